// ===== sv/hth_pkg.sv =====
// Shared types, widths and status codes for the tunnel identifier hash table.
package hth_pkg;

  localparam int KEY_W       = 32;
  localparam int HANDLE_W    = 32;
  localparam int STATUS_W    = 2;
  localparam int BUCKETS_DEF = 256;
  localparam int WAYS_DEF    = 4;

  // Operation codes carried in the request's op field.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  // One request as accepted on the input side.
  typedef struct packed {
    logic                op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  // One result as delivered on the output side.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
  } rsp_t;

endpackage

// ===== sv/hth_front.sv =====
// Front end: accepts requests and works out the bucket as key modulo the bucket count.
module hth_front import hth_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int BW      = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  req_t          in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output req_t          out_req,
  output logic [BW-1:0] out_bucket
);

  localparam bit POW2   = (BUCKETS == (1 << BW));
  localparam int STEPS  = 2;
  localparam int STEP_W = 1;
  localparam int MW     = KEY_W + 1;
  localparam int PW     = KEY_W + MW;

  // Rounded-up reciprocal of the bucket count, scaled so that the quotient of
  // every 32-bit key comes out exact from one multiply and a shift.
  localparam logic [63:0] MAGIC_FULL =
    ((64'd1 << (KEY_W + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [MW-1:0] MAGIC  = MAGIC_FULL[MW-1:0];
  localparam logic [BW-1:0] DIV_LO = BW'(BUCKETS);

  logic              busy;
  logic              hold;
  req_t              item;
  logic [BW-1:0]     rem;
  logic [BW-1:0]     quo;
  logic [PW-1:0]     prod;
  logic [2*BW-1:0]   qd;
  logic [STEP_W-1:0] cnt;
  logic              accept;

  assign in_ready   = !busy && !hold;
  assign accept     = in_valid && in_ready;
  assign out_valid  = hold;
  assign out_req    = item;
  assign out_bucket = rem;

  // Quotient from the reciprocal product; only its low bits are needed for the remainder.
  assign prod = PW'(item.key) * PW'(MAGIC);
  assign qd   = (2*BW)'(quo) * (2*BW)'(DIV_LO);

  // Control: idle, dividing, or holding a finished request for the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      hold <= 1'b0;
      cnt  <= '0;
    end else begin
      if (accept) begin
        if (POW2) begin
          hold <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= '0;
        end
      end else if (busy) begin
        cnt <= STEP_W'(cnt + 1'b1);
        if (cnt == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          hold <= 1'b1;
        end
      end else if (hold && out_ready) begin
        hold <= 1'b0;
      end
    end
  end

  // Payload and remainder datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_req;
      if (POW2) begin
        rem <= in_req.key[BW-1:0];
      end else begin
        rem <= '0;
      end
    end else if (busy) begin
      if (cnt == '0) begin
        quo <= prod[KEY_W+BW +: BW];
      end else begin
        rem <= item.key[BW-1:0] - qd[BW-1:0];
      end
    end
  end

endmodule

// ===== sv/hth_queue.sv =====
// Two-entry queue between the front end and the table back end.
module hth_queue import hth_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

  // The fill count never goes past the two slots.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

endmodule

// ===== sv/hth_back.sv =====
// Back end: bucket memory, clearing pass, way compare, insert write and result register.
module hth_back import hth_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF,
  parameter int BW      = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  req_t          in_req,
  input  logic [BW-1:0] in_bucket,
  output logic          out_valid,
  input  logic          out_ready,
  output rsp_t          out_rsp
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;

  // Bucket rows: one valid bit, key and handle per way.
  logic [WAYS-1:0]          mem_valid  [BUCKETS];
  logic [WAYS*KEY_W-1:0]    mem_key    [BUCKETS];
  logic [WAYS*HANDLE_W-1:0] mem_handle [BUCKETS];

  logic [1:0]               state;
  logic [BW-1:0]            clr_addr;
  req_t                     cur;
  logic [BW-1:0]            cur_bucket;
  logic [WAYS-1:0]          row_valid;
  logic [WAYS*KEY_W-1:0]    row_key;
  logic [WAYS*HANDLE_W-1:0] row_handle;

  logic                     pop;
  logic [WAYS-1:0]          match;
  logic [WAYS-1:0]          hit_oh;
  logic [WAYS-1:0]          free_oh;
  logic                     hit;
  logic                     have_free;
  logic [HANDLE_W-1:0]      hit_handle;
  logic [WAYS*KEY_W-1:0]    key_row_next;
  logic [WAYS*HANDLE_W-1:0] handle_row_next;
  logic                     ins_do;
  logic                     valid_wr;
  logic [BW-1:0]            valid_addr;
  logic [WAYS-1:0]          valid_data;
  rsp_t                     rsp_next;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign pop      = in_valid && in_ready;

  // Compare every way of the row and pick the lowest hit and lowest free way.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_valid[w] && (row_key[w*KEY_W +: KEY_W] == cur.key);
    end
    hit_oh     = match & (~match + WAYS'(1));
    free_oh    = ~row_valid & (row_valid + WAYS'(1));
    hit        = |match;
    have_free  = !(&row_valid);
    hit_handle = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) begin
        hit_handle = hit_handle | row_handle[w*HANDLE_W +: HANDLE_W];
      end
      key_row_next[w*KEY_W +: KEY_W] =
        free_oh[w] ? cur.key : row_key[w*KEY_W +: KEY_W];
      handle_row_next[w*HANDLE_W +: HANDLE_W] =
        free_oh[w] ? cur.handle : row_handle[w*HANDLE_W +: HANDLE_W];
    end
  end

  // Result and insert decision.
  always_comb begin
    ins_do          = 1'b0;
    rsp_next.handle = '0;
    if (cur.op == OP_LOOKUP) begin
      if (hit) begin
        rsp_next.status = ST_OK;
        rsp_next.handle = hit_handle;
      end else begin
        rsp_next.status = ST_MISSING;
      end
    end else if (hit) begin
      rsp_next.status = ST_PRESENT;
    end else if (have_free) begin
      rsp_next.status = ST_OK;
      ins_do          = (state == S_EVAL);
    end else begin
      rsp_next.status = ST_FULL;
    end
  end

  // Valid-row write port, shared by the clearing pass and inserts.
  assign valid_wr   = (state == S_CLEAR) || ins_do;
  assign valid_addr = (state == S_CLEAR) ? clr_addr : cur_bucket;
  assign valid_data = (state == S_CLEAR) ? '0 : (row_valid | free_oh);

  // Bucket memory: one row write and one registered row read per cycle.
  always_ff @(posedge clk) begin
    if (valid_wr) begin
      mem_valid[valid_addr] <= valid_data;
    end
    if (ins_do) begin
      mem_key[cur_bucket]    <= key_row_next;
      mem_handle[cur_bucket] <= handle_row_next;
    end
    if (pop) begin
      row_valid  <= mem_valid[in_bucket];
      row_key    <= mem_key[in_bucket];
      row_handle <= mem_handle[in_bucket];
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur        <= in_req;
      cur_bucket <= in_bucket;
    end
  end

  // Sequencer: clearing pass after reset, then read and evaluate per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= BW'(clr_addr + 1'b1);
          if (clr_addr == BW'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EVAL) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      out_rsp <= rsp_next;
    end
  end

  // Every evaluated request leaves exactly one result behind it.
  a_eval_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |=> out_valid)
    else $error("evaluated request left no result");

  // No request is taken while the table is still being cleared.
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pop)
    else $error("request taken during clearing pass");

  // Only a successful lookup carries a nonzero handle.
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_rsp.status != ST_OK)) |-> (out_rsp.handle == '0))
    else $error("nonzero handle on a failed request");

endmodule

// ===== sv/tunnel_id_hash_table.sv =====
// Top level of the tunnel identifier hash table: front end, queue and table back end.
//
//   Channel   Direction  Handshake                      Contents
//   s_axis    in         s_axis_tvalid / s_axis_tready  one lookup or insert request
//   m_axis    out        m_axis_tvalid / m_axis_tready  one status and handle per request
//
// With a power-of-two bucket count the front end takes the bucket from the low key bits;
// otherwise a reciprocal multiply and a remainder step come first. Either way it
// takes no new request until the last one has passed into the queue.
// The back end works through each request as a row read, then a compare and write.
// After reset the back end clears the valid row of every bucket; the front end
// and queue still take up to three requests meanwhile.
// A stalled output holds its result and the queue lets the front end keep working.
module tunnel_id_hash_table import hth_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,  // tunnel_key [31:0], entry_handle [63:32]
  input  logic                s_axis_tuser,  // op [0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,  // found_handle [31:0]
  output logic [STATUS_W-1:0] m_axis_tuser   // status [1:0]
);

  localparam int BW = $clog2(BUCKETS);
  localparam int QW = BW + $bits(req_t);

  req_t          in_req;
  rsp_t          rsp;
  logic          f_valid;
  logic          f_ready;
  req_t          f_req;
  logic [BW-1:0] f_bucket;
  logic          q_valid;
  logic          q_ready;
  logic [QW-1:0] q_data;
  req_t          q_req;
  logic [BW-1:0] q_bucket;

  // Unpack the incoming request.
  assign in_req.op     = s_axis_tuser;
  assign in_req.key    = s_axis_tdata[KEY_W-1:0];
  assign in_req.handle = s_axis_tdata[KEY_W +: HANDLE_W];

  hth_front #(
    .BUCKETS (BUCKETS),
    .BW      (BW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_req     (in_req),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_req    (f_req),
    .out_bucket (f_bucket)
  );

  hth_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_bucket, f_req}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  assign q_req    = q_data[$bits(req_t)-1:0];
  assign q_bucket = q_data[QW-1 -: BW];

  hth_back #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS),
    .BW      (BW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_req    (q_req),
    .in_bucket (q_bucket),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rsp   (rsp)
  );

  // Pack the result.
  assign m_axis_tdata = rsp.handle;
  assign m_axis_tuser = rsp.status;

endmodule

// ===== tb/sv/tb_tunnel_id_hash_table.sv =====
// Self-checking testbench for the tunnel identifier hash table: directed and random traffic.
module tb_tunnel_id_hash_table;
  import hth_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = BUCKETS_DEF * WAYS_DEF;
  localparam int DRAIN_CYCLES  = 20;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata = '0;  // tunnel_key [31:0], entry_handle [63:32]
  logic                s_axis_tuser = 1'b0;  // op [0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;  // found_handle [31:0]
  logic [STATUS_W-1:0] m_axis_tuser;  // status [1:0]

  // Shadow copy of the table contents.
  bit                  tbl_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0]    tbl_key [TABLE_ENTRIES];
  logic [HANDLE_W-1:0] tbl_handle [TABLE_ENTRIES];
  logic [KEY_W-1:0]    stored_keys[$];

  // Results still owed by the table, oldest first.
  rsp_t pending_results[$];

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_req = 0;

  tunnel_id_hash_table dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #400000;
    $display("tunnel_id_hash_table verification failed");
    $finish;
  end

  // Apply one request to the shadow table and return the result it must produce.
  function automatic rsp_t apply_table_request(logic op, logic [KEY_W-1:0] key,
                                               logic [HANDLE_W-1:0] handle);
    int unsigned base;
    int hit_idx;
    int free_idx;
    rsp_t r;
    base = (key % BUCKETS_DEF) * WAYS_DEF;
    hit_idx = -1;
    free_idx = -1;
    r.status = ST_OK;
    r.handle = '0;
    for (int w = 0; w < WAYS_DEF; w++) begin
      if (tbl_valid[base + w]) begin
        if (hit_idx < 0 && tbl_key[base + w] == key) hit_idx = base + w;
      end else if (free_idx < 0) begin
        free_idx = base + w;
      end
    end
    if (op == OP_LOOKUP) begin
      if (hit_idx >= 0) begin
        r.status = ST_OK;
        r.handle = tbl_handle[hit_idx];
      end else begin
        r.status = ST_MISSING;
      end
    end else if (hit_idx >= 0) begin
      r.status = ST_PRESENT;
    end else if (free_idx >= 0) begin
      tbl_valid[free_idx] = 1'b1;
      tbl_key[free_idx] = key;
      tbl_handle[free_idx] = handle;
      stored_keys.push_back(key);
      r.status = ST_OK;
    end else begin
      r.status = ST_FULL;
    end
    return r;
  endfunction

  // Offer one request, with an optional random gap, and record its expected result.
  // Called just after a rising edge; returns just after the edge that took the request.
  task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] handle);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {handle, key};
    s_axis_tuser  <= op;
    // Ready is stable at the falling edge and holds through the next rising edge.
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    pending_results.push_back(apply_table_request(op, key, handle));
  endtask

  // Stop offering and wait for every owed result, then let the pipeline settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Output side ready: random stalls, or a long hold-off counted here when requested.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_off_req > 0) begin
        hold_left = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Compare each delivered result with the oldest expectation.
  always @(negedge clk) begin
    rsp_t exp_rsp;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result status %0d handle %h", $realtime,
                 m_axis_tuser, m_axis_tdata);
      end else begin
        exp_rsp = pending_results.pop_front();
        if (m_axis_tuser !== exp_rsp.status) begin
          error_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d", $realtime,
                   exp_rsp.status, m_axis_tuser);
        end
        if (m_axis_tdata !== exp_rsp.handle) begin
          error_count++;
          $display("%0t: found_handle mismatch, expected %h, actual %h", $realtime,
                   exp_rsp.handle, m_axis_tdata);
        end
      end
    end
  end

  // Lookups on an empty table, including the key extremes.
  task automatic test_empty_table();
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'h8000_0001, 32'h1234_5678);
  endtask

  // Insert, find, and refuse a key that is already present.
  task automatic test_insert_and_lookup();
    send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0005);
    send_request(OP_LOOKUP, 32'h0000_0000, 32'hA5A5_A5A5);
  endtask

  // Fill one bucket through colliding keys, then overflow it.
  task automatic test_bucket_fill();
    send_request(OP_INSERT, 32'h0000_0100, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0200, 32'h0000_0002);
    send_request(OP_INSERT, 32'h0000_0300, 32'h0000_0003);
    send_request(OP_INSERT, 32'h0000_0400, 32'h0000_0004);
    send_request(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'h0000_0400, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h0000_0100, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h0000_0300, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0200, 32'h0000_0009);
  endtask

  // A stored handle of zero on the top key, and of all ones on another key in its bucket.
  task automatic test_handle_extremes();
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h7FFF_FEFF, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'h7FFF_FEFF, 32'h0000_0000);
  endtask

  // Pick a key: mostly reused or aimed at a few hot buckets so that they fill up.
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35 && stored_keys.size() > 0)
      return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    if (sel < 75)
      return ($urandom & 32'hFFFF_FF00) | 32'($urandom_range(16, 31));
    return $urandom;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random mix of lookups and inserts.
  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++)
      send_request(logic'($urandom_range(0, 1)), pick_key(), pick_handle());
  endtask

  // Output held off for a long stretch while requests keep coming, so the input stalls.
  task automatic test_output_backpressure();
    hold_off_req = 300;
    test_random_traffic(40);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_empty_table();
    test_insert_and_lookup();
    test_bucket_fill();
    test_handle_extremes();
    test_random_traffic(90);
    drain_results();

    send_idle_pct = 74;
    recv_stall_pct = 0;
    test_random_traffic(90);

    send_idle_pct = 0;
    recv_stall_pct = 74;
    test_random_traffic(90);

    send_idle_pct = 14;
    recv_stall_pct = 14;
    test_random_traffic(90);
    drain_results();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_output_backpressure();
    drain_results();

    if (error_count == 0) begin
      $display("tunnel_id_hash_table verification clean");
    end else begin
      $display("tunnel_id_hash_table verification failed");
    end
    $finish;
  end

endmodule
